@@ rtl/i64dec_pkg.sv @@
// ----------------------------------------------------------------------------
// i64dec_pkg
// Shared types and constants for the signed 64-bit to decimal ASCII unit.
// ----------------------------------------------------------------------------
package i64dec_pkg;

	// ASCII codes, six bits wide
	localparam logic [5:0] CH_MINUS = 6'd45;
	localparam logic [5:0] CH_ZERO  = 6'd48;

	// Conversion geometry
	localparam int VALUE_W    = 64;
	localparam int NUM_DIGITS = 20;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int STEP_BITS  = 4;
	localparam int CONV_STEPS = VALUE_W / STEP_BITS;
	localparam int CNT_W      = $clog2(CONV_STEPS);
	localparam int IDX_W      = $clog2(NUM_DIGITS);

	// Commands from controller to datapath
	typedef struct packed {
		logic load;        // capture input value
		logic step;        // one double-dabble step (four bits)
		logic prep;        // locate leading digit
		logic emit_sign;   // load '-' into output register
		logic emit_digit;  // load current digit into output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic negative;
		logic idx_zero;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/i64dec_ctrl.sv @@
// ----------------------------------------------------------------------------
// i64dec_ctrl
// Sequencer: accept, convert in sixteen steps, then emit sign and digits.
// ----------------------------------------------------------------------------
module i64dec_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  i64dec_pkg::stat_t stat,
	output i64dec_pkg::cmd_t  cmd
);
	import i64dec_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_PREP  = 5'b00100,
		ST_SIGN  = 5'b01000,
		ST_DIGIT = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CONV_STEPS - 1);

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = stat.negative ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				if (stat.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (stat.out_free) begin
					cmd.emit_digit = 1'b1;
					if (stat.idx_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Checks
	a_load_then_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.step)
		else $error("conversion did not start after load");

	a_prep_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prep |=> (state_q == ST_SIGN || state_q == ST_DIGIT))
		else $error("prep not followed by emission");

	a_sign_only_neg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prep && !stat.negative |=> !cmd.emit_sign)
		else $error("sign emitted for non-negative value");

endmodule

@@ rtl/i64dec_dp.sv @@
// ----------------------------------------------------------------------------
// i64dec_dp
// Datapath: magnitude, double-dabble BCD register, digit index, output stage.
// ----------------------------------------------------------------------------
module i64dec_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [63:0]              value,
	input  i64dec_pkg::cmd_t         cmd,
	output i64dec_pkg::stat_t        stat,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [5:0]               out_char,
	output logic                     out_last
);
	import i64dec_pkg::*;

	logic [VALUE_W-1:0] mag_q;
	logic [BCD_W-1:0]   bcd_q;
	logic               neg_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   top_idx;
	logic [DIGIT_W-1:0] cur_digit;
	logic               valid_q;
	logic [5:0]         char_q;
	logic               last_q;

	// Four double-dabble bit steps, MSB first
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b_in,
		input logic [STEP_BITS-1:0] bits);
		logic [BCD_W-1:0] b;
		b = b_in;
		for (int j = STEP_BITS - 1; j >= 0; j--) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (b[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
					b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], bits[j]};
		end
		return b;
	endfunction

	// Leading non-zero digit position (zero gives position 0)
	always_comb begin
		top_idx = '0;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] != '0) begin
				top_idx = IDX_W'(d);
			end
		end
	end

	assign cur_digit = bcd_q[{idx_q, 2'b00} +: DIGIT_W];

	// Conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[VALUE_W-1];
			mag_q <= value[VALUE_W-1] ? (~value + 64'd1) : value;
			bcd_q <= '0;
		end else if (cmd.step) begin
			bcd_q <= dd_step(bcd_q, mag_q[VALUE_W-1 -: STEP_BITS]);
			mag_q <= {mag_q[VALUE_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
		end
		if (cmd.prep) begin
			idx_q <= top_idx;
		end else if (cmd.emit_digit && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	// Output register: valid is control, character and last are payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CH_ZERO + {2'b00, cur_digit};
			last_q <= (idx_q == '0);
		end
	end

	assign out_valid     = valid_q;
	assign out_char      = char_q;
	assign out_last      = last_q;
	assign stat.negative = neg_q;
	assign stat.idx_zero = (idx_q == '0);
	assign stat.out_free = !valid_q || out_ready;

	// Checks
	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prep |=> (idx_q == '0 || cur_digit != '0))
		else $error("leading zero digit selected");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_digit && stat.idx_zero |=> out_last && out_valid)
		else $error("final digit not marked last");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit) |-> stat.out_free)
		else $error("output register overwritten");

endmodule

@@ rtl/int64_to_decimal_ascii_unit.sv @@
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_unit
// Signed 64-bit integer to decimal ASCII text, one character per transaction.
// ----------------------------------------------------------------------------
// One value is accepted at a time. After acceptance the magnitude is turned
// into twenty BCD digits by a double-dabble register taking four bits per
// cycle, a prep step then finds the leading digit, and then one character
// leaves per cycle while the output side is ready: '-' for a negative value,
// then the digits most significant first with no leading zeros, the final
// one with tlast. The next value is accepted only after that final
// character has been loaded into the output register.
module int64_to_decimal_ascii_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [5:0] ascii_char, [7:6] zero
	output logic        m_axis_tlast    // last
);
	import i64dec_pkg::*;

	cmd_t       cmd;
	stat_t      stat;
	logic [5:0] char_out;

	// Controller
	i64dec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath
	i64dec_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (char_out),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, char_out};

endmodule
